### rtl/core/ttg_pkg.sv
// Shared constants, types and the quarter-wave sine table for the tremolo tone generator.
package ttg_pkg;

	// Audio sample rate in hertz and quarter-wave table length (a power of two).
	localparam int SAMPLE_RATE     = 44100;
	localparam int SINE_TABLE_SIZE = 1024;

	localparam int POS_W    = $clog2(SAMPLE_RATE);
	localparam int IDX_W    = $clog2(SINE_TABLE_SIZE);
	localparam int PHASE_W  = IDX_W + 2;
	localparam int ADDR_W   = IDX_W + 1;

	localparam int OP_W       = 2;
	localparam int FREQ_W     = 12;
	localparam int AMP_W      = 15;
	localparam int DECAY_W    = 16;
	localparam int TREM_W     = 6;
	localparam int SAMPLE_W   = 16;
	localparam int WAVE_W     = 16;
	localparam int ROM_W      = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Product of two Q1.15 values and the amplitude, scaled back by 2^30.
	localparam int P1_W      = 2 * WAVE_W;
	localparam int PROD_W    = P1_W + AMP_W + 1;
	localparam int PROD_SHIFT = 30;

	// Iteration counts of the modular multiply and the phase scaling.
	localparam int MUL_STEPS = FREQ_W;
	localparam int DIV_STEPS = PHASE_W;
	localparam int RPT_W     = 4;
	localparam int PC_W      = 4;

	// Request opcodes.
	localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
	localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
	localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_START_AMP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TREMOLO_RATE = 2'd3;

	localparam logic [AMP_W-1:0]   START_AMP_RST    = 15'd3000;
	localparam logic [AMP_W-1:0]   RELEASE_STEP_RST = 15'd100;
	localparam logic [DECAY_W-1:0] DECAY_PERIOD_RST = 16'd4096;
	localparam logic [TREM_W-1:0]  TREMOLO_RATE_RST = 6'd4;

	// Datapath operation codes carried in each microcode word.
	typedef logic [3:0] dp_op_t;
	localparam dp_op_t DP_NOP    = 4'd0;
	localparam dp_op_t DP_MSTEP  = 4'd1;
	localparam dp_op_t DP_DSTEP  = 4'd2;
	localparam dp_op_t DP_RDSIN  = 4'd3;
	localparam dp_op_t DP_RDCOS  = 4'd4;
	localparam dp_op_t DP_CAPCOS = 4'd5;
	localparam dp_op_t DP_MUL1   = 4'd6;
	localparam dp_op_t DP_MUL2   = 4'd7;
	localparam dp_op_t DP_EMIT   = 4'd8;
	localparam dp_op_t DP_CMD    = 4'd9;

	typedef struct packed {
		logic   take;
		dp_op_t op;
	} dp_ctl_t;

	typedef struct packed {
		logic is_tick;
		logic out_free;
	} dp_status_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef logic [ROM_W-1:0] wave_rom_t [0:SINE_TABLE_SIZE];

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Quarter-wave sine in Q1.15 from an integer Q30 Taylor series.
	function automatic wave_rom_t build_rom();
		wave_rom_t   t;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		for (int k = 0; k <= SINE_TABLE_SIZE; k++) begin
			a = 64'(k) * HALF_PI_Q30 / 64'(SINE_TABLE_SIZE);
			a2 = (a * a) >> 30;
			term = a;
			sum = a;
			for (int n = 1; n <= 9; n += 2) begin
				term = ((term * a2) >> 30) / 64'((n + 1) * (n + 2));
				if ((((n + 1) / 2) & 1) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			t[k] = ROM_W'(v);
		end
		return t;
	endfunction

endpackage

### rtl/core/ttg_channels.sv
// Handshake channel interfaces for requests, samples and configuration writes.
interface ttg_item_if;
	logic                       valid;
	logic                       ready;
	logic [ttg_pkg::OP_W-1:0]   op;
	logic [ttg_pkg::FREQ_W-1:0] note_freq;

	modport source (output valid, output op, output note_freq, input ready);
	modport sink (input valid, input op, input note_freq, output ready);
endinterface

interface ttg_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [ttg_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface ttg_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ttg_pkg::CFG_IDX_W-1:0]  index;
	logic [ttg_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/ttg_wave_rom.sv
// Quarter-wave sine table with a registered read port.
module ttg_wave_rom (
	input  logic                        clk,
	input  logic [ttg_pkg::ADDR_W-1:0]  addr,
	output logic [ttg_pkg::ROM_W-1:0]   data
);

	localparam ttg_pkg::wave_rom_t ROM = ttg_pkg::build_rom();

	logic [ttg_pkg::ROM_W-1:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= ROM[addr];
	end

	assign data = data_q;

endmodule

### rtl/core/ttg_seq.sv
// Microcode sequencer: program counter, repeat counter and the control store.
module ttg_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  ttg_pkg::dp_status_t status,
	output ttg_pkg::dp_ctl_t    ctl
);

	typedef struct packed {
		ttg_pkg::dp_op_t               op;
		logic [ttg_pkg::RPT_W-1:0]     rpt;
		logic                          br;
		logic                          fin;
		logic [ttg_pkg::PC_W-1:0]      target;
	} uword_t;

	localparam logic [ttg_pkg::PC_W-1:0] PC_START = 4'd0;
	localparam logic [ttg_pkg::PC_W-1:0] PC_CMD   = 4'd8;

	// Control store. The first step branches to the command step unless the
	// request is a sample tick; otherwise it starts the modular multiply.
	function automatic uword_t prog_word(logic [ttg_pkg::PC_W-1:0] pc);
		uword_t w;
		w = '{op: ttg_pkg::DP_NOP, rpt: '0, br: 1'b0, fin: 1'b1, target: PC_START};
		case (pc)
			4'd0: w = '{op: ttg_pkg::DP_MSTEP,
				rpt: ttg_pkg::RPT_W'(ttg_pkg::MUL_STEPS - 1),
				br: 1'b1, fin: 1'b0, target: PC_CMD};
			4'd1: w = '{op: ttg_pkg::DP_DSTEP,
				rpt: ttg_pkg::RPT_W'(ttg_pkg::DIV_STEPS - 1),
				br: 1'b0, fin: 1'b0, target: PC_START};
			4'd2: w = '{op: ttg_pkg::DP_RDSIN, rpt: '0, br: 1'b0, fin: 1'b0, target: PC_START};
			4'd3: w = '{op: ttg_pkg::DP_RDCOS, rpt: '0, br: 1'b0, fin: 1'b0, target: PC_START};
			4'd4: w = '{op: ttg_pkg::DP_CAPCOS, rpt: '0, br: 1'b0, fin: 1'b0, target: PC_START};
			4'd5: w = '{op: ttg_pkg::DP_MUL1, rpt: '0, br: 1'b0, fin: 1'b0, target: PC_START};
			4'd6: w = '{op: ttg_pkg::DP_MUL2, rpt: '0, br: 1'b0, fin: 1'b0, target: PC_START};
			4'd7: w = '{op: ttg_pkg::DP_EMIT, rpt: '0, br: 1'b0, fin: 1'b1, target: PC_START};
			PC_CMD: w = '{op: ttg_pkg::DP_CMD, rpt: '0, br: 1'b0, fin: 1'b1, target: PC_START};
			default: w = '{op: ttg_pkg::DP_NOP, rpt: '0, br: 1'b0, fin: 1'b1, target: PC_START};
		endcase
		return w;
	endfunction

	logic                       busy_q;
	logic [ttg_pkg::PC_W-1:0]   pc_q;
	logic [ttg_pkg::RPT_W-1:0]  cnt_q;
	uword_t                     word;
	logic                       stall;
	logic                       branch;

	assign word = prog_word(pc_q);
	assign stall = (word.op == ttg_pkg::DP_EMIT) && !status.out_free;
	assign branch = word.br && !status.is_tick;
	assign item_ready = !busy_q;

	always_comb begin
		ctl.take = item_valid && !busy_q;
		ctl.op = ttg_pkg::DP_NOP;
		if (busy_q && !stall && !branch) begin
			ctl.op = word.op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q <= PC_START;
			cnt_q <= '0;
		end else if (!busy_q) begin
			if (item_valid) begin
				busy_q <= 1'b1;
				pc_q <= PC_START;
				cnt_q <= '0;
			end
		end else if (!stall) begin
			if (branch) begin
				pc_q <= word.target;
				cnt_q <= '0;
			end else if (cnt_q != word.rpt) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
				if (word.fin) begin
					busy_q <= 1'b0;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

endmodule

### rtl/core/ttg_datapath.sv
// Datapath: voice state, configuration registers, phase lanes, multiplier and output register.
module ttg_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ttg_pkg::dp_ctl_t                     ctl,
	output ttg_pkg::dp_status_t                  status,
	input  ttg_pkg::cfg_wr_t                     cfg_wr,
	input  logic [ttg_pkg::OP_W-1:0]             item_op,
	input  logic [ttg_pkg::FREQ_W-1:0]           item_freq,
	output logic [ttg_pkg::ADDR_W-1:0]           rom_addr,
	input  logic [ttg_pkg::ROM_W-1:0]            rom_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [ttg_pkg::SAMPLE_W-1:0]  out_sample
);

	localparam int POS_W   = ttg_pkg::POS_W;
	localparam int PHASE_W = ttg_pkg::PHASE_W;
	localparam int IDX_W   = ttg_pkg::IDX_W;
	localparam int ADDR_W  = ttg_pkg::ADDR_W;
	localparam int WAVE_W  = ttg_pkg::WAVE_W;
	localparam int QV_W    = ttg_pkg::PROD_W - ttg_pkg::PROD_SHIFT;

	localparam logic [POS_W+1:0] SR_X1 = (POS_W + 2)'(ttg_pkg::SAMPLE_RATE);
	localparam logic [POS_W+1:0] SR_X2 = (POS_W + 2)'(2 * ttg_pkg::SAMPLE_RATE);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(ttg_pkg::SAMPLE_RATE - 1);
	localparam logic [PHASE_W-1:0] QUARTER = PHASE_W'(ttg_pkg::SINE_TABLE_SIZE);
	localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(ttg_pkg::SINE_TABLE_SIZE);
	localparam logic signed [QV_W-1:0] QV_MAX = QV_W'(32767);
	localparam logic signed [QV_W-1:0] QV_MIN = -QV_W'(32768);

	// One step of (2*acc + bit*pos) mod SAMPLE_RATE, MSB first over the multiplier.
	function automatic logic [POS_W-1:0] mod_mac(logic [POS_W-1:0] acc, logic [POS_W-1:0] pos,
			logic b);
		logic [POS_W+1:0] t;
		t = (POS_W + 2)'({acc, 1'b0}) + (b ? (POS_W + 2)'(pos) : '0);
		if (t >= SR_X2) begin
			t = t - SR_X2;
		end else if (t >= SR_X1) begin
			t = t - SR_X1;
		end
		return t[POS_W-1:0];
	endfunction

	// One restoring-division step of the residue shifted by one bit.
	function automatic logic [POS_W:0] div_step(logic [POS_W-1:0] acc);
		logic [POS_W+1:0] t;
		t = (POS_W + 2)'({acc, 1'b0});
		if (t >= SR_X1) begin
			t = t - SR_X1;
			return {1'b1, t[POS_W-1:0]};
		end
		return {1'b0, t[POS_W-1:0]};
	endfunction

	function automatic logic [ADDR_W-1:0] wave_addr(logic [PHASE_W-1:0] ph);
		logic [ADDR_W-1:0] r;
		r = {1'b0, ph[IDX_W-1:0]};
		return ph[IDX_W] ? ADDR_TOP - r : r;
	endfunction

	function automatic logic signed [WAVE_W-1:0] wave_val(logic [ttg_pkg::ROM_W-1:0] d,
			logic neg);
		logic signed [WAVE_W-1:0] m;
		m = $signed({1'b0, d});
		return neg ? -m : m;
	endfunction

	// Configuration registers.
	logic [ttg_pkg::AMP_W-1:0]   start_amp_q;
	logic [ttg_pkg::AMP_W-1:0]   release_step_q;
	logic [ttg_pkg::DECAY_W-1:0] decay_period_q;
	logic [ttg_pkg::TREM_W-1:0]  tremolo_q;

	// Voice state.
	logic [POS_W-1:0]            pos_q;
	logic [ttg_pkg::FREQ_W-1:0]  tone_q;
	logic [ttg_pkg::AMP_W-1:0]   amp_q;
	logic [ttg_pkg::AMP_W-1:0]   rel_q;
	logic [ttg_pkg::DECAY_W-1:0] dcnt_q;

	// Request fields and work registers.
	logic [ttg_pkg::OP_W-1:0]    op_q;
	logic [ttg_pkg::FREQ_W-1:0]  freq_q;
	logic [POS_W-1:0]            acc_a_q;
	logic [POS_W-1:0]            acc_b_q;
	logic [ttg_pkg::FREQ_W-1:0]  mul_a_q;
	logic [ttg_pkg::FREQ_W-1:0]  mul_b_q;
	logic [PHASE_W-1:0]          ph_a_q;
	logic [PHASE_W-1:0]          ph_b_q;
	logic signed [WAVE_W-1:0]    sin_q;
	logic signed [WAVE_W-1:0]    cos_q;
	logic signed [ttg_pkg::P1_W-1:0]   p1_q;
	logic signed [ttg_pkg::PROD_W-1:0] p2_q;
	logic                        out_valid_q;
	logic signed [ttg_pkg::SAMPLE_W-1:0] out_sample_q;

	logic [PHASE_W-1:0]          ph_cos;
	logic [POS_W:0]              dstep_a;
	logic [POS_W:0]              dstep_b;
	logic signed [QV_W-1:0]      qv;
	logic signed [ttg_pkg::SAMPLE_W-1:0] sat;
	logic [ttg_pkg::DECAY_W-1:0] dcnt_inc;
	logic                        decay_hit;

	// Cosine is the sine a quarter turn ahead.
	assign ph_cos = ph_b_q + QUARTER;
	assign rom_addr = (ctl.op == ttg_pkg::DP_RDSIN) ? wave_addr(ph_a_q) : wave_addr(ph_cos);
	assign dstep_a = div_step(acc_a_q);
	assign dstep_b = div_step(acc_b_q);

	// Floor division by 2^30 is an arithmetic shift.
	assign qv = p2_q[ttg_pkg::PROD_W-1:ttg_pkg::PROD_SHIFT];

	always_comb begin
		if (qv > QV_MAX) begin
			sat = ttg_pkg::SAMPLE_W'(QV_MAX);
		end else if (qv < QV_MIN) begin
			sat = ttg_pkg::SAMPLE_W'(QV_MIN);
		end else begin
			sat = qv[ttg_pkg::SAMPLE_W-1:0];
		end
	end

	assign dcnt_inc = dcnt_q + 1'b1;
	assign decay_hit = (dcnt_inc >= decay_period_q) || (dcnt_inc == '0);

	assign status.is_tick = (op_q == ttg_pkg::OP_TICK);
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_sample = out_sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_amp_q <= ttg_pkg::START_AMP_RST;
			release_step_q <= ttg_pkg::RELEASE_STEP_RST;
			decay_period_q <= ttg_pkg::DECAY_PERIOD_RST;
			tremolo_q <= ttg_pkg::TREMOLO_RATE_RST;
		end else if (cfg_wr.we) begin
			case (cfg_wr.index)
				ttg_pkg::CFG_START_AMP: begin
					start_amp_q <= cfg_wr.data[ttg_pkg::AMP_W-1:0];
				end
				ttg_pkg::CFG_RELEASE_STEP: begin
					release_step_q <= cfg_wr.data[ttg_pkg::AMP_W-1:0];
				end
				ttg_pkg::CFG_DECAY_PERIOD: begin
					decay_period_q <= cfg_wr.data[ttg_pkg::DECAY_W-1:0];
				end
				ttg_pkg::CFG_TREMOLO_RATE: begin
					tremolo_q <= cfg_wr.data[ttg_pkg::TREM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			tone_q <= '0;
			amp_q <= '0;
			rel_q <= '0;
			dcnt_q <= '0;
			op_q <= ttg_pkg::OP_TICK;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.take) begin
				op_q <= item_op;
			end
			if (ctl.op == ttg_pkg::DP_EMIT) begin
				out_valid_q <= 1'b1;
				pos_q <= (pos_q >= POS_LAST) ? '0 : pos_q + 1'b1;
				if (decay_hit) begin
					dcnt_q <= '0;
					amp_q <= (amp_q > rel_q) ? amp_q - rel_q : '0;
				end else begin
					dcnt_q <= dcnt_inc;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.op == ttg_pkg::DP_CMD) begin
				case (op_q)
					ttg_pkg::OP_NOTE_ON: begin
						rel_q <= '0;
						if (freq_q != '0) begin
							tone_q <= freq_q;
							amp_q <= start_amp_q;
						end else begin
							amp_q <= '0;
						end
					end
					ttg_pkg::OP_NOTE_OFF: begin
						rel_q <= release_step_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Work registers hold payload only and need no reset.
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			freq_q <= item_freq;
			acc_a_q <= '0;
			acc_b_q <= '0;
			mul_a_q <= tone_q;
			mul_b_q <= ttg_pkg::FREQ_W'(tremolo_q);
		end
		case (ctl.op)
			ttg_pkg::DP_MSTEP: begin
				acc_a_q <= mod_mac(acc_a_q, pos_q, mul_a_q[ttg_pkg::FREQ_W-1]);
				acc_b_q <= mod_mac(acc_b_q, pos_q, mul_b_q[ttg_pkg::FREQ_W-1]);
				mul_a_q <= {mul_a_q[ttg_pkg::FREQ_W-2:0], 1'b0};
				mul_b_q <= {mul_b_q[ttg_pkg::FREQ_W-2:0], 1'b0};
			end
			ttg_pkg::DP_DSTEP: begin
				acc_a_q <= dstep_a[POS_W-1:0];
				acc_b_q <= dstep_b[POS_W-1:0];
				ph_a_q <= {ph_a_q[PHASE_W-2:0], dstep_a[POS_W]};
				ph_b_q <= {ph_b_q[PHASE_W-2:0], dstep_b[POS_W]};
			end
			ttg_pkg::DP_RDCOS: begin
				sin_q <= wave_val(rom_data, ph_a_q[IDX_W+1]);
			end
			ttg_pkg::DP_CAPCOS: begin
				cos_q <= wave_val(rom_data, ph_cos[IDX_W+1]);
			end
			ttg_pkg::DP_MUL1: begin
				p1_q <= ttg_pkg::P1_W'(sin_q) * ttg_pkg::P1_W'(cos_q);
			end
			ttg_pkg::DP_MUL2: begin
				p2_q <= ttg_pkg::PROD_W'(p1_q) * ttg_pkg::PROD_W'($signed({1'b0, amp_q}));
			end
			ttg_pkg::DP_EMIT: begin
				out_sample_q <= sat;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/core/tremolo_tone_generator_core.sv
// Top level of the tremolo tone generator: sequencer, datapath and sine table.
//
// Mono tone generator with tremolo. Each request is a sample tick, a note-on
// or a note-off; a tick returns one saturated 16-bit sample, the others return
// nothing. The block takes one request at a time. A tick runs through
// twelve steps of the modular multiplier for both phases, one lane each,
// twelve steps of phase scaling, then the table reads, two multiplies and
// the output write; the write waits only while the previous sample has not
// been taken. A note-on or note-off branches from the first step to the command step.
// The output register lets a finished sample wait while the next request is
// taken. Configuration writes go straight into the registers and must be
// made only while no request is in progress.
module tremolo_tone_generator_core (
	input  logic              clk,
	input  logic              arst_n,
	ttg_item_if.sink          item,
	ttg_sample_if.source      result,
	ttg_cfg_if.sink           cfg
);

	ttg_pkg::dp_ctl_t                 ctl;
	ttg_pkg::dp_status_t              status;
	ttg_pkg::cfg_wr_t                 cfg_wr;
	logic [ttg_pkg::ADDR_W-1:0]       rom_addr;
	logic [ttg_pkg::ROM_W-1:0]        rom_data;

	assign cfg.ready = 1'b1;
	assign cfg_wr.we = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data = cfg.data;

	ttg_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.ctl        (ctl)
	);

	ttg_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.status     (status),
		.cfg_wr     (cfg_wr),
		.item_op    (item.op),
		.item_freq  (item.note_freq),
		.rom_addr   (rom_addr),
		.rom_data   (rom_data),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_sample (result.sample)
	);

	ttg_wave_rom u_wave_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

endmodule
